// ===== rtl/core/pps_pkg.sv =====
// Package for the projection profile segmenter core.
// Sizes, register indexes and the sequencer state type; no dependencies.
`default_nettype none

package pps_pkg;

    localparam int MAX_LINE = 1024;
    localparam int LINE_W   = $clog2(MAX_LINE);
    localparam int CNT_W    = LINE_W + 1;
    localparam int PIX_W    = 8;
    localparam int MEAN_W   = 8;
    localparam int SUM_MAX  = MAX_LINE * 255;
    localparam int SUM_W    = $clog2(SUM_MAX + 1);
    localparam int DIV_W    = CNT_W + MEAN_W;
    localparam int STEP_W   = $clog2(MEAN_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LEVEL = 1'b1;

    localparam logic [7:0] BLANK_LEVEL_RESET = 8'd253;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_DONE
    } pps_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/projection_profile_segmenter_core.sv =====
// Projection profile segmenter: line sums, line means and runs of non-blank lines.
// Depends on pps_pkg; holds the per-column sum memory and a shift-subtract divider.
//
// Usage: pixels enter on in_valid/in_stall in row-major order, one word per
// pixel, with row_last on the last pixel of each row and in_last_row on every
// pixel of the final row. Results leave on out_valid/out_stall, one word per
// profiled line. Row mode (orientation 0) emits at each row end; column mode
// (orientation 1) emits at each pixel of the last row.
// Flow: a row-mode pixel that ends no line leaves in_stall low; a column-mode
// pixel passes the column memory read, then write-back (ST_RMW). A pixel that
// emits then runs the divider (ST_DIV) and the result state (ST_DONE) before
// the next pixel is taken. The mean comes from an 8-step restoring divider,
// one quotient bit per cycle.
// The result sits in an output register; the next pixel is taken while it
// waits. If out_stall holds and a second result completes, the core holds
// in_stall until the register frees.
// Reset clears counters, run state and registers (orientation 0, blank
// level 253); the column memory needs no clearing.
`default_nettype none

module projection_profile_segmenter_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0] wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pps_pkg::PIX_W-1:0]    pixel_value,
    input  wire logic                         row_last,
    input  wire logic                         in_last_row,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pps_pkg::LINE_W-1:0]        line_index,
    output logic [pps_pkg::MEAN_W-1:0]        line_mean,
    output logic                              line_blank,
    output logic                              run_closed,
    output logic [pps_pkg::LINE_W-1:0]        run_begin,
    output logic [pps_pkg::LINE_W:0]          run_end
);
    import pps_pkg::*;

    localparam logic [SUM_W-1:0]  SUM_SAT   = SUM_W'(SUM_MAX);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINE - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_LINE);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MEAN_W - 1);

    pps_state_t state_reg, state_next;

    logic              orient_reg, orient_next;
    logic [7:0]        level_reg, level_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [LINE_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0]  rows_reg, rows_next;
    logic              run_open_reg, run_open_next;
    logic [LINE_W-1:0] run_start_reg, run_start_next;

    logic [SUM_W-1:0]  col_mem [MAX_LINE];
    logic [SUM_W-1:0]  mem_rdata;
    logic              mem_we;

    logic [LINE_W-1:0] wcol_reg, wcol_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              first_row_reg, first_row_next;
    logic              emit_reg, emit_next;
    logic              edge_reg, edge_next;
    logic [LINE_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [MEAN_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sat_reg, sat_next;

    logic              ov_reg, ov_next;
    logic [LINE_W-1:0] o_idx_reg, o_idx_next;
    logic [MEAN_W-1:0] o_mean_reg, o_mean_next;
    logic              o_blank_reg, o_blank_next;
    logic              o_closed_reg, o_closed_next;
    logic [LINE_W-1:0] o_begin_reg, o_begin_next;
    logic [LINE_W:0]   o_end_reg, o_end_next;

    logic              accept;
    logic              out_free;
    logic [SUM_W:0]    row_sum_wide;
    logic [SUM_W-1:0]  row_sum;
    logic [SUM_W:0]    col_sum_wide;
    logic [SUM_W-1:0]  col_sum;
    logic [SUM_W-1:0]  div_sum;
    logic [CNT_W-1:0]  div_cnt;
    logic [CNT_W-1:0]  rows_inc;
    logic [MEAN_W-1:0] mean;
    logic              blank;
    logic [LINE_W-1:0] start_idx;

    assign accept   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    assign row_sum_wide = {1'b0, acc_reg} + (SUM_W + 1)'(pixel_value);
    assign row_sum      = (row_sum_wide > (SUM_W + 1)'(SUM_SAT)) ? SUM_SAT
                                                                 : row_sum_wide[SUM_W-1:0];
    assign col_sum_wide = {1'b0, mem_rdata} + (SUM_W + 1)'(pix_reg);
    assign col_sum      = first_row_reg ? SUM_W'(pix_reg)
                        : (col_sum_wide > (SUM_W + 1)'(SUM_SAT)) ? SUM_SAT
                        : col_sum_wide[SUM_W-1:0];
    assign rows_inc     = rows_reg + CNT_W'(1);

    assign div_sum = (state_reg == ST_RMW) ? col_sum : row_sum;
    assign div_cnt = (state_reg == ST_RMW) ? cnt_reg : ({1'b0, col_reg} + CNT_W'(1));

    assign mean      = sat_reg ? {MEAN_W{1'b1}} : quo_reg;
    assign blank     = mean >= level_reg;
    assign start_idx = run_open_reg ? run_start_reg : idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (orient_reg)
                        state_next = ST_RMW;
                    else if (row_last)
                        state_next = ST_DIV;
                end
            end
            ST_RMW:
            begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        mem_we   = (state_reg == ST_RMW);
    end

    // datapath
    always_comb
    begin
        orient_next    = orient_reg;
        level_next     = level_reg;
        acc_next       = acc_reg;
        col_next       = col_reg;
        rows_next      = rows_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        wcol_next      = wcol_reg;
        pix_next       = pix_reg;
        first_row_next = first_row_reg;
        emit_next      = emit_reg;
        edge_next      = edge_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        ov_next        = ov_reg && out_stall;
        o_idx_next     = o_idx_reg;
        o_mean_next    = o_mean_reg;
        o_blank_next   = o_blank_reg;
        o_closed_next  = o_closed_reg;
        o_begin_next   = o_begin_reg;
        o_end_next     = o_end_reg;

        if (wr_en)
        begin
            unique case (wr_index)
                CFG_ORIENTATION: orient_next = wr_data[0];
                CFG_BLANK_LEVEL: level_next  = wr_data[7:0];
                default:         orient_next = orient_reg;
            endcase
        end

        if (accept)
        begin
            wcol_next      = col_reg;
            pix_next       = pixel_value;
            first_row_next = (rows_reg == '0);
            if (orient_reg)
            begin
                emit_next = in_last_row;
                edge_next = row_last;
                idx_next  = col_reg;
                cnt_next  = (rows_reg >= CNT_MAX) ? CNT_MAX : rows_inc;
            end
            else
            begin
                acc_next  = row_sum;
                emit_next = row_last;
                edge_next = in_last_row;
                idx_next  = (rows_reg > CNT_W'(LINE_LAST)) ? LINE_LAST
                                                           : rows_reg[LINE_W-1:0];
            end
            if (row_last)
            begin
                acc_next = '0;
                col_next = '0;
                if (in_last_row)
                    rows_next = '0;
                else if (rows_reg < CNT_MAX)
                    rows_next = rows_inc;
            end
            else if (col_reg < LINE_LAST)
            begin
                col_next = col_reg + LINE_W'(1);
            end
        end

        // divider load: from the row sum at accept, or the column sum at write-back
        if (state_next == ST_DIV && state_reg != ST_DIV)
        begin
            rem_next  = DIV_W'(div_sum);
            dvs_next  = {1'b0, div_cnt, {(MEAN_W - 1){1'b0}}};
            quo_next  = '0;
            step_next = '0;
            sat_next  = DIV_W'(div_sum) >= {div_cnt, {MEAN_W{1'b0}}};
        end

        if (state_reg == ST_DIV)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[MEAN_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[MEAN_W-2:0], 1'b0};
            end
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg + STEP_W'(1);
        end

        if (state_reg == ST_DONE && out_free)
        begin
            ov_next       = 1'b1;
            o_idx_next    = idx_reg;
            o_mean_next   = mean;
            o_blank_next  = blank;
            o_closed_next = 1'b0;
            o_begin_next  = '0;
            o_end_next    = '0;
            if (blank)
            begin
                if (run_open_reg)
                begin
                    o_closed_next = 1'b1;
                    o_begin_next  = run_start_reg;
                    o_end_next    = {1'b0, idx_reg};
                    run_open_next = 1'b0;
                end
            end
            else
            begin
                run_open_next  = 1'b1;
                run_start_next = start_idx;
                if (edge_reg)
                begin
                    o_closed_next = 1'b1;
                    o_begin_next  = start_idx;
                    o_end_next    = {1'b0, idx_reg} + (LINE_W + 1)'(1);
                    run_open_next = 1'b0;
                end
            end
        end
    end

    // column sum memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            col_mem[wcol_reg] <= col_sum;
        if (accept)
            mem_rdata <= col_mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            orient_reg    <= 1'b0;
            level_reg     <= BLANK_LEVEL_RESET;
            acc_reg       <= '0;
            col_reg       <= '0;
            rows_reg      <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            orient_reg    <= orient_next;
            level_reg     <= level_next;
            acc_reg       <= acc_next;
            col_reg       <= col_next;
            rows_reg      <= rows_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wcol_reg      <= wcol_next;
        pix_reg       <= pix_next;
        first_row_reg <= first_row_next;
        emit_reg      <= emit_next;
        edge_reg      <= edge_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        sat_reg       <= sat_next;
        o_idx_reg     <= o_idx_next;
        o_mean_reg    <= o_mean_next;
        o_blank_reg   <= o_blank_next;
        o_closed_reg  <= o_closed_next;
        o_begin_reg   <= o_begin_next;
        o_end_reg     <= o_end_next;
    end

    assign out_valid  = ov_reg;
    assign line_index = o_idx_reg;
    assign line_mean  = o_mean_reg;
    assign line_blank = o_blank_reg;
    assign run_closed = o_closed_reg;
    assign run_begin  = o_begin_reg;
    assign run_end    = o_end_reg;

endmodule

`default_nettype wire

// ===== bench/projection_profile_segmenter_core_tb.sv =====
// Testbench for projection_profile_segmenter_core: a directed table, random frames, then a tall frame.
// Depends on pps_pkg and the core; every line result is predicted here and checked in order.
module projection_profile_segmenter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYC     = 12;
    localparam int DRAIN_CYC   = 16;
    localparam int HOLD_CYC    = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_ITEMS  = 450;
    localparam int TALL_ROWS   = 1026;
    localparam int END_W       = LINE_W + 1;
    localparam int DIR_N       = 24;

    typedef struct packed {
        logic [LINE_W-1:0] line_index;
        logic [MEAN_W-1:0] line_mean;
        logic              line_blank;
        logic              run_closed;
        logic [LINE_W-1:0] run_begin;
        logic [END_W-1:0]  run_end;
    } line_res_t;

    typedef enum logic {DIR_PIX, DIR_REG} dir_op_t;
    typedef enum int {INK_BLANK, INK_MIX, INK_ANY} ink_t;

    typedef struct packed {
        dir_op_t               op;
        logic [PIX_W-1:0]      pix;
        logic                  rl;
        logic                  lr;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  typed;
        line_res_t             res;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_value;
    logic                  row_last;
    logic                  in_last_row;
    logic                  out_valid;
    logic                  out_stall;
    logic [LINE_W-1:0]     line_index;
    logic [MEAN_W-1:0]     line_mean;
    logic                  line_blank;
    logic                  run_closed;
    logic [LINE_W-1:0]     run_begin;
    logic [END_W-1:0]      run_end;

    // predictor state and registers
    logic                  cfg_orient = 1'b0;
    logic [7:0]            cfg_blank  = BLANK_LEVEL_RESET;
    logic [SUM_W-1:0]      row_acc    = '0;
    logic [LINE_W-1:0]     col_pos    = '0;
    logic [CNT_W-1:0]      rows_cnt   = '0;
    logic [SUM_W-1:0]      col_sum [MAX_LINE];
    bit                    run_on     = 1'b0;
    logic [LINE_W-1:0]     run_first  = '0;

    line_res_t pending_lines [$];
    dir_row_t  dir_tab [DIR_N];
    int        fail_cnt = 0;
    int        idle_cyc = 0;
    int        px_sent  = 0;
    int        tx_pct   = 0;
    int        rx_pct   = 0;
    int        hold_req = 0;
    int        hold_ack = 0;

    projection_profile_segmenter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .row_last    (row_last),
        .in_last_row (in_last_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_index  (line_index),
        .line_mean   (line_mean),
        .line_blank  (line_blank),
        .run_closed  (run_closed),
        .run_begin   (run_begin),
        .run_end     (run_end)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic int sat_sum(input int a, input int b);
        int s;
        s = a + b;
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    function automatic int line_avg(input int sum, input int cnt);
        int m;
        if (cnt == 0)
            cnt = 1;
        m = sum / cnt;
        return (m > 255) ? 255 : m;
    endfunction

    function automatic bit profile_pixel(input logic [PIX_W-1:0] p, input bit rl, input bit lr,
                                         output line_res_t res);
        int pos, rows, sum, cnt, idx, mean;
        bit emit, at_edge, blank;
        pos = int'(col_pos);
        rows = int'(rows_cnt);
        emit = 1'b0;
        at_edge = 1'b0;
        idx = 0;
        mean = 0;
        res = '0;
        if (!cfg_orient)
        begin
            sum = sat_sum(int'(row_acc), int'(p));
            row_acc = SUM_W'(sum);
            if (rl)
            begin
                emit = 1'b1;
                at_edge = lr;
                idx = (rows > MAX_LINE - 1) ? MAX_LINE - 1 : rows;
                mean = line_avg(sum, pos + 1);
            end
        end
        else
        begin
            sum = (rows == 0) ? int'(p) : sat_sum(int'(col_sum[pos]), int'(p));
            col_sum[pos] = SUM_W'(sum);
            if (lr)
            begin
                emit = 1'b1;
                at_edge = rl;
                idx = pos;
                cnt = (rows + 1 > MAX_LINE) ? MAX_LINE : rows + 1;
                mean = line_avg(sum, cnt);
            end
        end
        if (rl)
        begin
            row_acc = '0;
            col_pos = '0;
            if (lr)
                rows_cnt = '0;
            else if (rows < MAX_LINE)
                rows_cnt = CNT_W'(rows + 1);
        end
        else if (pos < MAX_LINE - 1)
        begin
            col_pos = LINE_W'(pos + 1);
        end
        if (emit)
        begin
            blank = (mean >= int'(cfg_blank));
            res.line_index = LINE_W'(idx);
            res.line_mean = MEAN_W'(mean);
            res.line_blank = blank;
            if (blank)
            begin
                if (run_on)
                begin
                    res.run_closed = 1'b1;
                    res.run_begin = run_first;
                    res.run_end = END_W'(idx);
                    run_on = 1'b0;
                end
            end
            else
            begin
                if (!run_on)
                begin
                    run_on = 1'b1;
                    run_first = LINE_W'(idx);
                end
                // image edge closes an open run
                if (at_edge)
                begin
                    res.run_closed = 1'b1;
                    res.run_begin = run_first;
                    res.run_end = END_W'(idx + 1);
                    run_on = 1'b0;
                end
            end
        end
        return emit;
    endfunction

    function automatic dir_row_t px(input int p, input bit rl, input bit lr);
        dir_row_t d;
        d = '0;
        d.op = DIR_PIX;
        d.pix = PIX_W'(p);
        d.rl = rl;
        d.lr = lr;
        return d;
    endfunction

    function automatic dir_row_t px_exp(input int p, input bit rl, input bit lr, input int idx,
                                        input int mean, input bit blank, input bit closed,
                                        input int rb, input int re);
        dir_row_t d;
        d = px(p, rl, lr);
        d.typed = 1'b1;
        d.res = '{LINE_W'(idx), MEAN_W'(mean), blank, closed, LINE_W'(rb), END_W'(re)};
        return d;
    endfunction

    function automatic dir_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx, input int val);
        dir_row_t d;
        d = '0;
        d.op = DIR_REG;
        d.reg_idx = idx;
        d.reg_val = CFG_DATA_W'(val);
        return d;
    endfunction

    function automatic logic [PIX_W-1:0] ink_pixel(input ink_t k);
        case (k)
            INK_BLANK: return PIX_W'(253 + $urandom_range(2));
            INK_MIX:   return $urandom_range(1) ? 8'd0 : 8'd255;
            default:   return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit rl, input bit lr,
                              input bit typed, input line_res_t tres);
        line_res_t pred;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_value <= p;
        row_last <= rl;
        in_last_row <= lr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        px_sent++;
        if (profile_pixel(p, rl, lr, pred))
            pending_lines.push_back(typed ? tres : pred);
    endtask

    task automatic await_drain();
        in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        // a pixel that emits nothing may still be in flight
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= CFG_DATA_W'(val);
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_ORIENTATION)
            cfg_orient = val[0];
        else
            cfg_blank = 8'(val);
        @(posedge clk);
    endtask

    // column mode: later rows never run past the first row of the frame
    task automatic send_frame(input int rows, input int max_w, input bit noisy);
        ink_t col_ink [16];
        ink_t row_ink;
        int   w, first_w;
        bit   fin, lr_f;
        first_w = max_w;
        foreach (col_ink[c])
            col_ink[c] = ink_t'($urandom_range(2));
        for (int r = 0; r < rows; r++)
        begin
            fin = (r == rows - 1);
            w = (cfg_orient && r > 0) ? $urandom_range(1, first_w) : $urandom_range(1, max_w);
            if (r == 0)
                first_w = w;
            row_ink = ink_t'($urandom_range(2));
            for (int c = 0; c < w; c++)
            begin
                lr_f = fin;
                if (noisy && c != w - 1 && $urandom_range(3) == 0)
                    lr_f = !fin;
                send_pixel(ink_pixel(cfg_orient ? col_ink[c] : row_ink), c == w - 1, lr_f,
                           1'b0, '0);
            end
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
            end
            out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin
        line_res_t got, want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (out_valid && !out_stall)
            begin
                got = '{line_index, line_mean, line_blank, run_closed, run_begin, run_end};
                if (pending_lines.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected: idx=%0d mean=%0d blank=%0b closed=%0b %0d..%0d",
                                 got.line_index, got.line_mean, got.line_blank,
                                 got.run_closed, got.run_begin, got.run_end);
                end
                else
                begin
                    want = pending_lines.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("mismatch: exp idx=%0d mean=%0d blank=%0b closed=%0b %0d..%0d",
                                     want.line_index, want.line_mean, want.line_blank,
                                     want.run_closed, want.run_begin, want.run_end);
                            $display("          got idx=%0d mean=%0d blank=%0b closed=%0b %0d..%0d",
                                     got.line_index, got.line_mean, got.line_blank,
                                     got.run_closed, got.run_begin, got.run_end);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (idle_cyc >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stop_at;
        int lvl;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        pixel_value = '0;
        row_last = 1'b0;
        in_last_row = 1'b0;
        dir_tab = '{
            px_exp(255, 1, 0, 0, 255, 1, 0, 0, 0),
            px(0, 0, 0),
            px_exp(0, 1, 0, 1, 0, 0, 0, 0, 0),
            px_exp(252, 1, 0, 2, 252, 0, 0, 0, 0),
            px_exp(253, 1, 0, 3, 253, 1, 1, 1, 3),
            px_exp(10, 1, 1, 4, 10, 0, 1, 4, 5),
            reg_wr(CFG_BLANK_LEVEL, 0),
            px_exp(0, 1, 1, 0, 0, 1, 0, 0, 0),
            reg_wr(CFG_ORIENTATION, 1),
            reg_wr(CFG_BLANK_LEVEL, 255),
            px(255, 0, 0),
            px(0, 0, 0),
            px(7, 1, 0),
            px_exp(255, 0, 1, 0, 255, 1, 0, 0, 0),
            px_exp(1, 0, 1, 1, 0, 0, 0, 0, 0),
            px_exp(8, 1, 1, 2, 7, 0, 1, 1, 3),
            reg_wr(CFG_BLANK_LEVEL, 128),
            reg_wr(CFG_ORIENTATION, 0),
            px(200, 0, 0),
            px(201, 0, 0),
            px(255, 0, 0),
            px(0, 1, 0),
            px(5, 0, 1),
            px(250, 1, 1)
        };
        repeat (RST_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == DIR_REG)
            begin
                await_drain();
                write_reg(dir_tab[i].reg_idx, int'(dir_tab[i].reg_val));
            end
            else
            begin
                send_pixel(dir_tab[i].pix, dir_tab[i].rl, dir_tab[i].lr, dir_tab[i].typed,
                           dir_tab[i].res);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_pct = (ph == 0) ? 22 : (ph == 1) ? 48 : 0;
            rx_pct = (ph == 0) ? 48 : (ph == 1) ? 22 : 0;
            stop_at = px_sent + RAND_ITEMS / 3;
            while (px_sent < stop_at)
            begin
                if ($urandom_range(3) == 0)
                begin
                    await_drain();
                    write_reg(CFG_ORIENTATION, $urandom_range(1));
                    case ($urandom_range(4))
                        0:       lvl = 0;
                        1:       lvl = 255;
                        2:       lvl = BLANK_LEVEL_RESET;
                        default: lvl = $urandom_range(255);
                    endcase
                    write_reg(CFG_BLANK_LEVEL, lvl);
                end
                send_frame($urandom_range(1, 10),
                           ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 6),
                           $urandom_range(3) == 0);
            end
        end

        // too many rows in row mode, with the output held off at the start
        await_drain();
        write_reg(CFG_ORIENTATION, 0);
        write_reg(CFG_BLANK_LEVEL, BLANK_LEVEL_RESET);
        hold_req++;
        for (int r = 0; r < TALL_ROWS; r++)
            send_pixel(ink_pixel(ink_t'($urandom_range(2))), 1'b1, r == TALL_ROWS - 1,
                       1'b0, '0);

        await_drain();
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_cnt == 0 && pending_lines.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
